@@ design/dsu_pkg.sv @@
`timescale 1ns / 1ps

package dsu_pkg;

    localparam int NUM_ELEMENTS = 1024;
    localparam int IDX_W        = $clog2(NUM_ELEMENTS);
    localparam int LINK_W       = IDX_W + 1;

    typedef logic [IDX_W-1:0]         t_idx;
    typedef logic signed [LINK_W-1:0] t_link;

    localparam logic OP_MERGE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // how the current node pointer moves
    typedef enum logic [1:0] {
        CUR_HOLD,
        CUR_A,
        CUR_B,
        CUR_PARENT
    } t_cur_sel;

    // table port operation for this cycle
    typedef enum logic [2:0] {
        MEM_IDLE,
        MEM_READ,
        MEM_CLEAR,
        MEM_COMPRESS,
        MEM_MRG_SIZE,
        MEM_MRG_LINK
    } t_mem_op;

    typedef struct packed {
        logic     load;
        t_cur_sel cur_sel;
        logic     side;
        logic     root_we;
        logic     clr_step;
        t_mem_op  mem_op;
        logic     out_load;
    } t_dsu_cmd;

    typedef struct packed {
        logic in_range;
        logic is_query;
        logic rd_neg;
        logic cur_is_root;
        logic same_root;
        logic clr_last;
        logic out_free;
    } t_dsu_status;

endpackage

@@ design/dsu_if.sv @@
`timescale 1ns / 1ps

interface dsu_in_if;
    logic             valid;
    logic             ready;
    logic             opcode;
    dsu_pkg::t_idx    elem_a;
    dsu_pkg::t_idx    elem_b;

    modport source (output valid, output opcode, output elem_a, output elem_b, input ready);
    modport sink   (input valid, input opcode, input elem_a, input elem_b, output ready);
endinterface

interface dsu_out_if;
    logic valid;
    logic ready;
    logic same_set;

    modport source (output valid, output same_set, input ready);
    modport sink   (input valid, input same_set, output ready);
endinterface

@@ design/dsu_datapath.sv @@
`timescale 1ns / 1ps

module dsu_datapath (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  dsu_pkg::t_dsu_cmd     i_cmd,
    output dsu_pkg::t_dsu_status  o_status,
    input  logic                  i_opcode,
    input  dsu_pkg::t_idx         i_elem_a,
    input  dsu_pkg::t_idx         i_elem_b,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic                  o_same_set
);
    import dsu_pkg::*;

    t_link mem [NUM_ELEMENTS];
    t_link r_rd_data;

    logic  r_op;
    t_idx  r_a, r_b, r_cur;
    t_idx  r_root_a, r_root_b;
    t_link r_size_a, r_size_b;
    t_idx  r_clr_idx;
    logic  r_out_valid, r_same;

    t_idx  w_addr;
    logic  w_we;
    t_link w_wdata;
    t_idx  w_root_side;
    t_idx  w_parent;
    logic  w_a_lt;
    logic  w_same_root;
    logic  w_in_range;
    t_link w_sum;

    assign w_parent    = r_rd_data[IDX_W-1:0];
    assign w_root_side = i_cmd.side ? r_root_b : r_root_a;
    assign w_a_lt      = r_size_a < r_size_b;
    assign w_sum       = r_size_a + r_size_b;
    assign w_same_root = (r_root_a == r_root_b);
    assign w_in_range  = (LINK_W'(r_a) < LINK_W'(NUM_ELEMENTS))
                      && (LINK_W'(r_b) < LINK_W'(NUM_ELEMENTS));

    always_comb begin
        w_addr  = r_cur;
        w_we    = 1'b0;
        w_wdata = '1;
        case (i_cmd.mem_op)
            MEM_CLEAR: begin
                w_addr  = r_clr_idx;
                w_we    = 1'b1;
                w_wdata = '1;
            end
            MEM_COMPRESS: begin
                w_we    = 1'b1;
                w_wdata = {1'b0, w_root_side};
            end
            MEM_MRG_SIZE: begin
                w_addr  = w_a_lt ? r_root_a : r_root_b;
                w_we    = 1'b1;
                w_wdata = w_sum;
            end
            MEM_MRG_LINK: begin
                w_addr  = w_a_lt ? r_root_b : r_root_a;
                w_we    = 1'b1;
                w_wdata = {1'b0, (w_a_lt ? r_root_a : r_root_b)};
            end
            default: begin
                w_addr = r_cur;
                w_we   = 1'b0;
            end
        endcase
    end

    // single-port table, registered read
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_addr] <= w_wdata;
        end
        r_rd_data <= mem[w_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_opcode;
            r_a   <= i_elem_a;
            r_b   <= i_elem_b;
            r_cur <= i_elem_a;
        end else begin
            case (i_cmd.cur_sel)
                CUR_A:      r_cur <= r_a;
                CUR_B:      r_cur <= r_b;
                CUR_PARENT: r_cur <= w_parent;
                default:    r_cur <= r_cur;
            endcase
        end
        if (i_cmd.root_we) begin
            if (i_cmd.side) begin
                r_root_b <= r_cur;
                r_size_b <= r_rd_data;
            end else begin
                r_root_a <= r_cur;
                r_size_a <= r_rd_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_idx   <= '0;
            r_out_valid <= 1'b0;
            r_same      <= 1'b0;
        end else begin
            if (i_cmd.clr_step) begin
                r_clr_idx <= r_clr_idx + 1'b1;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
                r_same      <= w_in_range && w_same_root;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_status.in_range    = w_in_range;
    assign o_status.is_query    = (r_op == OP_QUERY);
    assign o_status.rd_neg      = r_rd_data[LINK_W-1];
    assign o_status.cur_is_root = (r_cur == w_root_side);
    assign o_status.same_root   = w_same_root;
    assign o_status.clr_last    = (r_clr_idx == IDX_W'(NUM_ELEMENTS - 1));
    assign o_status.out_free    = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_same_set  = r_same;

endmodule

@@ design/dsu_controller.sv @@
`timescale 1ns / 1ps

module dsu_controller (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  dsu_pkg::t_dsu_status  i_status,
    output dsu_pkg::t_dsu_cmd     o_cmd
);
    import dsu_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_WALK_RD,
        S_WALK_CHK,
        S_CMP_RD,
        S_CMP_CHK,
        S_MRG_SIZE,
        S_MRG_LINK,
        S_RESULT
    } t_state;

    t_state r_state, n_state;
    logic   r_side, n_side;
    logic   w_path_done;

    always_comb begin
        n_state        = r_state;
        n_side         = r_side;
        w_path_done    = 1'b0;
        o_in_ready     = 1'b0;
        o_cmd.load     = 1'b0;
        o_cmd.cur_sel  = CUR_HOLD;
        o_cmd.side     = r_side;
        o_cmd.root_we  = 1'b0;
        o_cmd.clr_step = 1'b0;
        o_cmd.mem_op   = MEM_IDLE;
        o_cmd.out_load = 1'b0;

        unique case (r_state)
            S_CLEAR: begin
                o_cmd.mem_op   = MEM_CLEAR;
                o_cmd.clr_step = 1'b1;
                if (i_status.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_side     = 1'b0;
                    n_state    = S_WALK_RD;
                end
            end
            S_WALK_RD: begin
                if (!i_status.in_range) begin
                    n_state = i_status.is_query ? S_RESULT : S_IDLE;
                end else begin
                    o_cmd.mem_op = MEM_READ;
                    n_state      = S_WALK_CHK;
                end
            end
            S_WALK_CHK: begin
                if (i_status.rd_neg) begin
                    o_cmd.root_we = 1'b1;
                    o_cmd.cur_sel = r_side ? CUR_B : CUR_A;
                    n_state       = S_CMP_RD;
                end else begin
                    o_cmd.cur_sel = CUR_PARENT;
                    n_state       = S_WALK_RD;
                end
            end
            S_CMP_RD: begin
                if (i_status.cur_is_root) begin
                    w_path_done = 1'b1;
                end else begin
                    o_cmd.mem_op = MEM_READ;
                    n_state      = S_CMP_CHK;
                end
            end
            S_CMP_CHK: begin
                if (i_status.rd_neg) begin
                    w_path_done = 1'b1;
                end else begin
                    o_cmd.mem_op  = MEM_COMPRESS;
                    o_cmd.cur_sel = CUR_PARENT;
                    n_state       = S_CMP_RD;
                end
            end
            S_MRG_SIZE: begin
                o_cmd.mem_op = MEM_MRG_SIZE;
                n_state      = S_MRG_LINK;
            end
            S_MRG_LINK: begin
                o_cmd.mem_op = MEM_MRG_LINK;
                n_state      = S_IDLE;
            end
            S_RESULT: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (w_path_done) begin
            if (!r_side) begin
                n_side        = 1'b1;
                o_cmd.cur_sel = CUR_B;
                n_state       = S_WALK_RD;
            end else if (i_status.is_query) begin
                n_state = S_RESULT;
            end else if (i_status.same_root) begin
                n_state = S_IDLE;
            end else begin
                n_state = S_MRG_SIZE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_side  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_side  <= n_side;
        end
    end

endmodule

@@ design/disjoint_set_union_find.sv @@
`timescale 1ns / 1ps

// Union-find engine over NUM_ELEMENTS elements with union by size and full
// path compression, kept in one single-port link table (negative entry = root
// holding minus its set size, otherwise the parent index). After reset the
// block sweeps the table to all roots of size one, one entry a cycle, before
// the first item is accepted. An item is then accepted and, for each of its
// two elements at depth d below its root, the block walks up to the root and
// then rewrites the path to point at the root; a merge of two sets then writes
// the new size and the link, a merge within one set ends there, and a query
// posts its answer once the output register is free. Every read and write of
// the walks shares the single table port. Union by size keeps d at most log2 N.
// One item is in work at a time; a query answer waits in the output register
// while the next item is already accepted.

module disjoint_set_union_find (
    input  logic       i_clk,
    input  logic       i_rst_n,
    dsu_in_if.sink     i_in,
    dsu_out_if.source  o_out
);
    import dsu_pkg::*;

    t_dsu_cmd    w_cmd;
    t_dsu_status w_status;
    logic        w_in_ready;

    // sequencer: clear sweep, root walks, compression, link or answer
    dsu_controller u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (w_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // link table, node pointer, found roots and sizes, result register
    dsu_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_opcode    (i_in.opcode),
        .i_elem_a    (i_in.elem_a),
        .i_elem_b    (i_in.elem_b),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_same_set  (o_out.same_set)
    );

    assign i_in.ready = w_in_ready;

endmodule

@@ bench/dsu_result_checker.sv @@
`timescale 1ns / 1ps

module dsu_result_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    dsu_in_if    i_in,
    dsu_out_if   i_out,
    output int   o_fail_count,
    output int   o_pending
);

    import dsu_pkg::*;

    // shadow link table: negative = root holding minus set size, else parent
    t_link link_tbl [NUM_ELEMENTS];
    logic  same_set_q [$];
    int    errors;

    initial begin
        for (int i = 0; i < NUM_ELEMENTS; i++) begin
            link_tbl[i] = -1;
        end
        errors = 0;
    end

    // walk to the root, then point every node on the path straight at it
    function automatic t_idx find_root(input t_idx node);
        t_idx root;
        t_idx cur;
        t_idx nxt;
        root = node;
        while (link_tbl[root] >= 0) begin
            root = t_idx'(link_tbl[root]);
        end
        cur = node;
        while (cur != root) begin
            nxt           = t_idx'(link_tbl[cur]);
            link_tbl[cur] = t_link'({1'b0, root});
            cur           = nxt;
        end
        return root;
    endfunction

    function automatic void apply_item(input logic op, input t_idx a, input t_idx b);
        t_idx ra;
        t_idx rb;
        ra = find_root(a);
        rb = find_root(b);
        if (op == OP_QUERY) begin
            same_set_q.push_back(ra == rb);
        end else if (ra != rb) begin
            // smaller set goes under the larger, ties put a's root under b's
            if (link_tbl[ra] < link_tbl[rb]) begin
                link_tbl[ra] = link_tbl[ra] + link_tbl[rb];
                link_tbl[rb] = t_link'({1'b0, ra});
            end else begin
                link_tbl[rb] = link_tbl[rb] + link_tbl[ra];
                link_tbl[ra] = t_link'({1'b0, rb});
            end
        end
    endfunction

    function automatic void note_error(input string msg);
        errors++;
        if (errors <= 10) begin
            $display("[%0t] dsu check: %s", $time, msg);
        end
    endfunction

    always @(posedge i_clk) begin
        logic want;
        if (i_rst_n) begin
            // a result can never stem from the item taken on the same edge
            if (i_out.valid && i_out.ready) begin
                if (same_set_q.size() == 0) begin
                    note_error($sformatf("unexpected result, same_set %0b", i_out.same_set));
                end else begin
                    want = same_set_q.pop_front();
                    if (i_out.same_set !== want) begin
                        note_error($sformatf("same_set expected %0b, got %0b",
                                             want, i_out.same_set));
                    end
                end
            end
            if (i_in.valid && i_in.ready) begin
                apply_item(i_in.opcode, i_in.elem_a, i_in.elem_b);
            end
        end
        o_pending    <= same_set_q.size();
        o_fail_count <= errors;
    end

endmodule

@@ bench/disjoint_set_union_find_tb.sv @@
`timescale 1ns / 1ps

module disjoint_set_union_find_tb;

    import dsu_pkg::*;

    // the limit leaves a wide margin over the slowest item
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int HOLD_CYCLES  = 600;
    localparam int DRAIN_CYCLES = 120;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    int cycle_count = 0;
    int fail_count;
    int pending;

    // idle controls, written by the stimulus and read by the sender and the receiver
    bit tx_idle_on = 1'b0;
    bit rx_idle_on = 1'b0;
    int hold_reqs  = 0;

    dsu_in_if  in_ch ();
    dsu_out_if out_ch ();

    always #5 i_clk = ~i_clk;

    disjoint_set_union_find i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    dsu_result_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // watchdog: a hung handshake ends the run here
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("disjoint_set_union_find_tb: FAIL");
            $finish;
        end
    end

    // receiver: random back-pressure, plus a long hold when asked for one
    initial begin
        int hold_done;
        hold_done    = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_reqs != hold_done) begin
                // hold counted here, the sender keeps pushing meanwhile
                hold_done = hold_reqs;
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                out_ch.ready <= rx_idle_on ? ($urandom_range(99) >= 33) : 1'b1;
            end
        end
    end

    // offer one item, with an optional random gap before it, and wait until taken
    task automatic offer_item(input logic op, input t_idx a, input t_idx b);
        while (tx_idle_on && $urandom_range(99) < 33) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid  <= 1'b1;
        in_ch.opcode <= op;
        in_ch.elem_a <= a;
        in_ch.elem_b <= b;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    // mostly elements from a narrow window so sets grow and trees get deep,
    // now and then any element at all
    function automatic t_idx pick_elem(input int base, input int span);
        if ($urandom_range(9) == 0) begin
            return t_idx'($urandom_range(NUM_ELEMENTS - 1));
        end
        return t_idx'((base + $urandom_range(span - 1)) % NUM_ELEMENTS);
    endfunction

    task automatic run_random(input int count);
        int   base;
        int   span;
        logic op;
        t_idx a;
        t_idx b;
        base = 0;
        span = 4;
        for (int n = 0; n < count; n++) begin
            // move the window every few items, span 4, 16 or 64
            if (n % 16 == 0) begin
                base = $urandom_range(NUM_ELEMENTS - 1);
                span = 4 << (2 * $urandom_range(2));
            end
            op = $urandom_range(1) ? OP_QUERY : OP_MERGE;
            a  = pick_elem(base, span);
            b  = ($urandom_range(19) == 0) ? a : pick_elem(base, span);
            offer_item(op, a, b);
        end
    endtask

    // pending is registered, so sample only after a fresh edge
    task automatic wait_drained();
        do @(posedge i_clk); while (pending != 0);
    endtask

    initial begin
        int base;
        in_ch.valid  = 1'b0;
        in_ch.opcode = OP_MERGE;
        in_ch.elem_a = '0;
        in_ch.elem_b = '0;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part, no idling; the table sweep after reset just delays
        // the first handshake
        offer_item(OP_QUERY, 10'd0,    10'd0);     // same element, lowest index
        offer_item(OP_QUERY, 10'd0,    10'd1023);  // two singletons
        offer_item(OP_MERGE, 10'd0,    10'd1023);  // equal sizes, a's root goes under b's
        offer_item(OP_QUERY, 10'd1023, 10'd0);
        offer_item(OP_MERGE, 10'd1023, 10'd0);     // already one set
        offer_item(OP_MERGE, 10'h155,  10'h2AA);
        offer_item(OP_MERGE, 10'h1FF,  10'h200);
        offer_item(OP_MERGE, 10'h155,  10'h200);   // two sets of two
        offer_item(OP_MERGE, 10'h3FE,  10'h001);
        offer_item(OP_MERGE, 10'h001,  10'h000);   // two against two again
        offer_item(OP_MERGE, 10'h200,  10'h3FE);   // four against four, deeper paths
        offer_item(OP_QUERY, 10'h155,  10'h001);   // deep on both sides, compresses
        offer_item(OP_QUERY, 10'h155,  10'h155);   // same element after compression
        offer_item(OP_MERGE, 10'd7,    10'h155);   // small set named first
        offer_item(OP_MERGE, 10'h155,  10'd8);     // large set named first
        offer_item(OP_QUERY, 10'd7,    10'd8);
        offer_item(OP_QUERY, 10'd7,    10'd9);
        offer_item(OP_QUERY, 10'h3FF,  10'h3FF);   // highest index
        offer_item(OP_MERGE, 10'h3FF,  10'h3FF);   // merge with itself
        offer_item(OP_QUERY, 10'h2AA,  10'h3FE);
        offer_item(OP_QUERY, 10'h3FF,  10'h000);

        // random items with gaps on both sides
        tx_idle_on <= 1'b1;
        rx_idle_on <= 1'b1;
        run_random(400);

        // long stretch at full rate
        tx_idle_on <= 1'b0;
        rx_idle_on <= 1'b0;
        run_random(300);

        // receiver holds off while queries keep coming, so the output
        // register fills and the block stops taking items
        hold_reqs <= hold_reqs + 1;
        base = $urandom_range(NUM_ELEMENTS - 1);
        for (int n = 0; n < 40; n++) begin
            offer_item(OP_QUERY, pick_elem(base, 64), pick_elem(base, 64));
        end

        // sender pauses until every answer is back
        in_ch.valid <= 1'b0;
        wait_drained();

        tx_idle_on <= 1'b1;
        rx_idle_on <= 1'b1;
        run_random(400);

        in_ch.valid <= 1'b0;
        wait_drained();
        // a trailing merge may still be in work, give it time to show up
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && pending == 0) begin
            $display("disjoint_set_union_find_tb: PASS");
        end else begin
            $display("disjoint_set_union_find_tb: FAIL");
        end
        $finish;
    end

endmodule

@@ sim.f @@
design/dsu_pkg.sv
design/dsu_if.sv
design/dsu_datapath.sv
design/dsu_controller.sv
design/disjoint_set_union_find.sv
bench/dsu_result_checker.sv
bench/disjoint_set_union_find_tb.sv
